// ----- sv/rpc_pkg.sv -----
// rpc_pkg: shared types, widths and the arctangent table of the point rotator
// used by rotate_point_about_center and rpc_cordic; depends on nothing
`default_nettype none

package rpc_pkg;

  // item field widths
  localparam int COORD_W = 24;
  localparam int ANGLE_W = 16;

  // internal number formats
  localparam int TURN_W      = 32;              // binary angle, full turn over 2^32
  localparam int Z_W         = TURN_W + 1;      // residual angle with headroom
  localparam int OFF_W       = COORD_W + 1;     // point minus center
  localparam int GAIN_W      = 31;              // signed q30 gain
  localparam int PROD_W      = OFF_W + GAIN_W;
  localparam int GUARD_SHIFT = 6;
  localparam int DP_W        = 52;              // rotation datapath, 2^-24 lsb
  localparam int OUT_SHIFT   = 24;
  localparam int RND_W       = DP_W - OUT_SHIFT;
  localparam int SUM_W       = RND_W + 1;
  localparam int STEPS       = 28;
  localparam int STEP_IDX_W  = $clog2(STEPS);

  localparam logic signed [GAIN_W-1:0] GAIN_Q30 = 31'sd652032874;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic        [ANGLE_W-1:0] turn_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] rotated_x;
    logic signed [COORD_W-1:0] rotated_y;
  } out_item_t;

  // state of one item inside the rotation stages
  typedef struct packed {
    logic signed [DP_W-1:0]    x;
    logic signed [DP_W-1:0]    y;
    logic signed [Z_W-1:0]     z;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } cordic_t;

  // atan(2^-i) in 2^32-per-turn units
  function automatic logic [TURN_W-1:0] atan_turn(input logic [STEP_IDX_W-1:0] i);
    logic [TURN_W-1:0] t;
    unique case (i)
      5'd0:    t = 32'h20000000;
      5'd1:    t = 32'h12E4051E;
      5'd2:    t = 32'h09FB385B;
      5'd3:    t = 32'h051111D4;
      5'd4:    t = 32'h028B0D43;
      5'd5:    t = 32'h0145D7E1;
      5'd6:    t = 32'h00A2F61E;
      5'd7:    t = 32'h00517C55;
      5'd8:    t = 32'h0028BE53;
      5'd9:    t = 32'h00145F2F;
      5'd10:   t = 32'h000A2F98;
      5'd11:   t = 32'h000517CC;
      5'd12:   t = 32'h00028BE6;
      5'd13:   t = 32'h000145F3;
      5'd14:   t = 32'h0000A2FA;
      5'd15:   t = 32'h0000517D;
      5'd16:   t = 32'h000028BE;
      5'd17:   t = 32'h0000145F;
      5'd18:   t = 32'h00000A30;
      5'd19:   t = 32'h00000518;
      5'd20:   t = 32'h0000028C;
      5'd21:   t = 32'h00000146;
      5'd22:   t = 32'h000000A3;
      5'd23:   t = 32'h00000051;
      5'd24:   t = 32'h00000029;
      5'd25:   t = 32'h00000014;
      5'd26:   t = 32'h0000000A;
      5'd27:   t = 32'h00000005;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// ----- sv/rpc_cordic.sv -----
// rpc_cordic: one register stage per cordic micro-rotation, 28 stages
// depends on rpc_pkg for cordic_t, widths and the arctangent table
`default_nettype none

module rpc_cordic import rpc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  logic    src_valid,
  input  cordic_t src,
  output logic    dst_valid,
  output cordic_t dst
);

  cordic_t            stg [1:STEPS];
  logic [STEPS:1]     vld;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    cordic_t                cur;
    logic                   cur_v;
    logic signed [DP_W-1:0] xs;
    logic signed [DP_W-1:0] ys;
    logic signed [Z_W-1:0]  t;

    if (i == 0) begin : g_first
      assign cur   = src;
      assign cur_v = src_valid;
    end else begin : g_rest
      assign cur   = stg[i];
      assign cur_v = vld[i];
    end

    assign xs = cur.x >>> i;
    assign ys = cur.y >>> i;
    assign t  = {1'b0, atan_turn(STEP_IDX_W'(i))};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= cur_v;
      end
    end

    // both updates use the old x and y
    always_ff @(posedge clk) begin
      if (en) begin
        stg[i+1].cx <= cur.cx;
        stg[i+1].cy <= cur.cy;
        if (!cur.z[Z_W-1]) begin
          stg[i+1].x <= cur.x - ys;
          stg[i+1].y <= cur.y + xs;
          stg[i+1].z <= cur.z - t;
        end else begin
          stg[i+1].x <= cur.x + ys;
          stg[i+1].y <= cur.y - xs;
          stg[i+1].z <= cur.z + t;
        end
      end
    end
  end

  assign dst_valid = vld[STEPS];
  assign dst       = stg[STEPS];

endmodule

`default_nettype wire

// ----- sv/rotate_point_about_center.sv -----
// rotate_point_about_center: top level of the pipelined point rotator
// depends on rpc_pkg and rpc_cordic
//
// usage
//   pt channel carries one item per point: point, center and a binary angle
//   (65536 units to a full turn, counter-clockwise). rot channel returns the
//   point rotated about the center, saturated to the 24-bit coordinate range.
//   an item is taken at a clock edge where valid is high and stall is low.
// pipeline
//   rot_valid is the last of 33 register stages, the first loaded at the
//   accepting edge: one input stage (offset and angle fold), one multiply
//   by the cordic gain, one scale and negate stage, 28 micro-rotation
//   stages, one rounding stage and the output register.
//   one item per cycle while pt_stall is low; every item gives one result.
// reset
//   synchronous rst clears all valid bits; data path registers are not reset.
// stalls
//   while rot_stall holds a waiting result, the stages still advance as long
//   as the last stage is empty, so bubbles close up and pt keeps taking
//   items; once the last stage holds an item too, pt_stall rises.
`default_nettype none

module rotate_point_about_center import rpc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      pt_valid,
  output logic      pt_stall,
  input  in_item_t  pt_data,
  output logic      rot_valid,
  input  logic      rot_stall,
  output out_item_t rot_data
);

  localparam logic signed [DP_W-1:0] ROUND_BIAS =
    {{(DP_W-OUT_SHIFT+1){1'b0}}, {(OUT_SHIFT-1){1'b0}}} | (DP_W'(1) << (OUT_SHIFT-1));
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'((64'sd1 <<< (COORD_W-1)) - 1);
  localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX - SUM_W'(1);

  // pipeline advance: output register free, or a bubble at the last stage
  logic out_load;
  logic en;

  // stage 0: offsets and folded angle
  logic                      v0;
  logic signed [OFF_W-1:0]   dx0, dy0;
  logic signed [COORD_W-1:0] cx0, cy0;
  logic                      flip0;
  logic signed [Z_W-1:0]     z0;

  // stage 1: gain products
  logic                      v1;
  logic signed [PROD_W-1:0]  px1, py1;
  logic signed [COORD_W-1:0] cx1, cy1;
  logic                      flip1;
  logic signed [Z_W-1:0]     z1;

  // stage 2: start vector of the rotation
  logic                      v2;
  cordic_t                   c2;

  // rotation result
  logic                      cv;
  cordic_t                   co;

  // stage 3: rounded rotated offset
  logic                      v3;
  logic signed [RND_W-1:0]   rx3, ry3;
  logic signed [COORD_W-1:0] cx3, cy3;

  // angle fold into the right half-plane
  logic [TURN_W-1:0]         turn;
  logic                      flip;
  logic [TURN_W-1:0]         turn_adj;

  logic signed [DP_W-1:0]    xs2, ys2;
  logic signed [SUM_W-1:0]   sum_x, sum_y;

  assign out_load = !rot_valid || !rot_stall;
  assign en       = out_load || !v3;
  assign pt_stall = !en;

  assign turn     = {pt_data.turn_angle, {(TURN_W-ANGLE_W){1'b0}}};
  assign flip     = turn[TURN_W-1] ^ turn[TURN_W-2];
  assign turn_adj = {turn[TURN_W-1] ^ flip, turn[TURN_W-2:0]};

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v0 <= pt_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= cv;
    end
  end

  // stage 0: offset of the point from the center, exact
  always_ff @(posedge clk) begin
    if (en) begin
      dx0   <= OFF_W'(pt_data.point_x) - OFF_W'(pt_data.center_x);
      dy0   <= OFF_W'(pt_data.point_y) - OFF_W'(pt_data.center_y);
      cx0   <= pt_data.center_x;
      cy0   <= pt_data.center_y;
      flip0 <= flip;
      z0    <= {turn_adj[TURN_W-1], turn_adj};
    end
  end

  // stage 1: pre-scale by the inverse cordic gain
  always_ff @(posedge clk) begin
    if (en) begin
      px1   <= dx0 * GAIN_Q30;
      py1   <= dy0 * GAIN_Q30;
      cx1   <= cx0;
      cy1   <= cy0;
      flip1 <= flip0;
      z1    <= z0;
    end
  end

  // stage 2: drop guard bits, negate for angles in the left half-plane
  assign xs2 = DP_W'(px1 >>> GUARD_SHIFT);
  assign ys2 = DP_W'(py1 >>> GUARD_SHIFT);

  always_ff @(posedge clk) begin
    if (en) begin
      c2.x  <= flip1 ? -xs2 : xs2;
      c2.y  <= flip1 ? -ys2 : ys2;
      c2.z  <= z1;
      c2.cx <= cx1;
      c2.cy <= cy1;
    end
  end

  rpc_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .src_valid (v2),
    .src       (c2),
    .dst_valid (cv),
    .dst       (co)
  );

  // stage 3: round half up back to coordinate units
  always_ff @(posedge clk) begin
    if (en) begin
      rx3 <= RND_W'((co.x + ROUND_BIAS) >>> OUT_SHIFT);
      ry3 <= RND_W'((co.y + ROUND_BIAS) >>> OUT_SHIFT);
      cx3 <= co.cx;
      cy3 <= co.cy;
    end
  end

  // add the center back and saturate
  assign sum_x = SUM_W'(rx3) + SUM_W'(cx3);
  assign sum_y = SUM_W'(ry3) + SUM_W'(cy3);

  function automatic logic signed [COORD_W-1:0] sat(input logic signed [SUM_W-1:0] s);
    logic signed [COORD_W-1:0] r;
    if (s > SUM_MAX) begin
      r = COORD_W'(SUM_MAX);
    end else if (s < SUM_MIN) begin
      r = COORD_W'(SUM_MIN);
    end else begin
      r = COORD_W'(s);
    end
    return r;
  endfunction

  // output register: holds while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      rot_valid <= 1'b0;
    end else if (out_load) begin
      rot_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rot_data.rotated_x <= sat(sum_x);
      rot_data.rotated_y <= sat(sum_y);
    end
  end

  // input is held back only when a result waits and the last stage is full
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    pt_stall |-> (rot_valid && rot_stall && v3))
    else $error("pt_stall without a blocked result behind it");

  // a frozen pipeline keeps its valid bits
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(v0) && $stable(v1) && $stable(v2) && $stable(v3)))
    else $error("pipeline valid bits moved while frozen");

  // nothing leaves right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!rot_valid && !v0 && !v3))
    else $error("valid bits set right after reset");

  // a waiting result is not overwritten by a bubble closing up
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (rot_valid && rot_stall) |=> rot_valid)
    else $error("waiting result dropped");

endmodule

`default_nettype wire

// ----- tb/tb_rotate_point_about_center.sv -----
// tb_rotate_point_about_center: self-checking testbench of the point rotator,
// with random idling on both channels and a bit-exact cordic predictor
// depends on rpc_pkg and rotate_point_about_center
`timescale 1ns / 1ps

module tb_rotate_point_about_center;
  import rpc_pkg::*;

  // run length and pacing
  localparam int RANDOM_ITEMS = 450;
  localparam int DRAIN_CYCLES = 48;      // quiet tail after the last result
  localparam int CYCLE_LIMIT  = 400000;  // several times the slowest legal run
  localparam int RESET_CYCLES = 12;

  // cordic constants, gain in q30 and atan(2^-i) per 2^32 turn
  localparam longint CORDIC_GAIN = 64'sd652032874;
  localparam longint HALF_OUT_LSB = 64'sd8388608;
  localparam int     ROT_STEPS = 28;
  localparam longint ATAN_TURN [ROT_STEPS] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
    64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
    64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005
  };

  localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;
  localparam int COORD_MIN = -(1 << (COORD_W - 1));

  // quadrant boundaries and the eighth turn of the 16-bit binary angle
  localparam logic [ANGLE_W-1:0] ANG_ZERO    = 16'h0000;
  localparam logic [ANGLE_W-1:0] ANG_QUARTER = 16'h4000;
  localparam logic [ANGLE_W-1:0] ANG_HALF    = 16'h8000;
  localparam logic [ANGLE_W-1:0] ANG_3QUART  = 16'hC000;
  localparam logic [ANGLE_W-1:0] ANG_EIGHTH  = 16'h2000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      pt_valid = 1'b0;
  logic      pt_stall;
  in_item_t  pt_data = '0;
  logic      rot_valid;
  logic      rot_stall = 1'b0;
  out_item_t rot_data;

  in_item_t  pending_points[$];       // items not yet offered to the block
  out_item_t expected_rotations[$];   // predictions of accepted items, oldest first

  int error_count  = 0;
  int result_count = 0;
  int cycle_count  = 0;

  // pacing state of each side
  int gap_left   = 0;
  int pt_calm    = 0;
  int stall_left = 0;
  int rot_calm   = 0;

  rotate_point_about_center u_dut (
    .clk       (clk),
    .rst       (rst),
    .pt_valid  (pt_valid),
    .pt_stall  (pt_stall),
    .pt_data   (pt_data),
    .rot_valid (rot_valid),
    .rot_stall (rot_stall),
    .rot_data  (rot_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // clamp to the signed coordinate range
  function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
    if (v > COORD_MAX) return COORD_W'(COORD_MAX);
    if (v < COORD_MIN) return COORD_W'(COORD_MIN);
    return COORD_W'(v);
  endfunction

  // bit-exact rotation of the point about the center
  function automatic out_item_t rotate_about_center(input in_item_t it);
    longint px, py, cx, cy;
    longint x, y, z, xs, ys;
    logic [31:0] turn;
    out_item_t r;
    px = longint'(it.point_x);
    py = longint'(it.point_y);
    cx = longint'(it.center_x);
    cy = longint'(it.center_y);
    // offsets scaled by the gain, lsb of 2^-24
    x = ((px - cx) * CORDIC_GAIN) >>> 6;
    y = ((py - cy) * CORDIC_GAIN) >>> 6;
    turn = {it.turn_angle, 16'h0000};
    // fold the second and third quadrant by a half turn
    if (turn[31:30] == 2'b01 || turn[31:30] == 2'b10) begin
      x = -x;
      y = -y;
      turn = turn + 32'h8000_0000;
    end
    z = longint'(signed'(turn));
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_TURN[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_TURN[i];
      end
    end
    // round half up back to coordinate lsb, then add the center back
    x = (x + HALF_OUT_LSB) >>> 24;
    y = (y + HALF_OUT_LSB) >>> 24;
    r.rotated_x = clamp_coord(x + cx);
    r.rotated_y = clamp_coord(y + cy);
    return r;
  endfunction

  // idle length: mostly short, a few long, with calm stretches of none
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 6) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic signed [COORD_W-1:0] random_coord();
    int v;
    case ($urandom_range(0, 4))
      0, 1: v = $urandom();
      2: v = $urandom_range(0, 8191) - 4096;
      3: begin
        v = $urandom_range(0, 255);
        v = $urandom_range(0, 1) ? COORD_MAX - v : COORD_MIN + v;
      end
      default: v = $urandom_range(0, 1048575) - 524288;
    endcase
    return COORD_W'(v);
  endfunction

  function automatic logic [ANGLE_W-1:0] random_angle();
    logic [ANGLE_W-1:0] base;
    if ($urandom_range(0, 9) < 8) return ANGLE_W'($urandom_range(0, 65535));
    // land right on or next to a quadrant boundary
    base = ANGLE_W'($urandom_range(0, 3)) << (ANGLE_W - 2);
    return base + ANGLE_W'($urandom_range(0, 2)) - ANGLE_W'(1);
  endfunction

  task automatic add_point(input int px, input int py, input int cx, input int cy,
                           input logic [ANGLE_W-1:0] ang);
    in_item_t it;
    it.point_x    = COORD_W'(px);
    it.point_y    = COORD_W'(py);
    it.center_x   = COORD_W'(cx);
    it.center_y   = COORD_W'(cy);
    it.turn_angle = ang;
    pending_points.push_back(it);
  endtask

  task automatic report_mismatch(input string what);
    $display("ERROR: cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // stimulus, reset and end of run
  initial begin
    in_item_t it;
    // every quadrant boundary on a plain offset, then angles next to each boundary
    add_point(25600, 0, 0, 0, ANG_ZERO);
    add_point(25600, 0, 0, 0, ANG_QUARTER);
    add_point(25600, 0, 0, 0, ANG_HALF);
    add_point(25600, 0, 0, 0, ANG_3QUART);
    add_point(25600, -12800, 256, 512, ANG_QUARTER - 1);
    add_point(25600, -12800, 256, 512, ANG_QUARTER + 1);
    add_point(-7000, 9000, -300, 100, ANG_HALF - 1);
    add_point(-7000, 9000, -300, 100, ANG_HALF + 1);
    add_point(123456, -654321, 1000, 2000, ANG_3QUART - 1);
    add_point(123456, -654321, 1000, 2000, 16'hFFFF);
    add_point(1, 1, 0, 0, ANG_EIGHTH);
    // point on the center returns the center
    add_point(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 16'h1234);
    add_point(-5555, 7777, -5555, 7777, ANG_HALF);
    add_point(0, 0, 0, 0, 16'hFFFF);
    // largest offsets and a point at the range edge, sums past the range saturate
    add_point(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, ANG_ZERO);
    add_point(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, ANG_ZERO);
    add_point(COORD_MAX, 0, COORD_MIN, 0, ANG_HALF);
    add_point(COORD_MAX, COORD_MAX, 0, 0, ANG_EIGHTH);
    add_point(COORD_MIN, COORD_MIN, 0, 0, ANG_EIGHTH);
    add_point(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, ANG_QUARTER);
    add_point(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, ANG_3QUART);
    add_point(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX - 1, ANG_QUARTER);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      it.point_x = random_coord();
      it.point_y = random_coord();
      if ($urandom_range(0, 3) == 0) begin
        // center close to the point, small offsets
        it.center_x = it.point_x + COORD_W'($urandom_range(0, 2047) - 1024);
        it.center_y = it.point_y + COORD_W'($urandom_range(0, 2047) - 1024);
      end else begin
        it.center_x = random_coord();
        it.center_y = random_coord();
      end
      it.turn_angle = random_angle();
      pending_points.push_back(it);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // all items accepted, all results in, then a quiet tail
    while (pending_points.size() != 0 || pt_valid) @(negedge clk);
    while (expected_rotations.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // driver: offers pending items, holds a stalled item unchanged
  always @(posedge clk) begin
    if (rst) begin
      pt_valid <= 1'b0;
      pt_data  <= '0;
    end else begin
      if (pt_valid && !pt_stall) begin
        expected_rotations.push_back(rotate_about_center(pt_data));
      end
      if (!(pt_valid && pt_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          pt_valid <= 1'b0;
        end else if (pending_points.size() != 0) begin
          pt_data  <= pending_points.pop_front();
          pt_valid <= 1'b1;
          gap_left = pick_gap(pt_calm);
        end else begin
          pt_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each taken result against the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      rot_stall <= 1'b0;
    end else begin
      if (rot_valid && !rot_stall) begin
        if (expected_rotations.size() == 0) begin
          report_mismatch($sformatf("result (%0d, %0d) with no item pending",
                                    rot_data.rotated_x, rot_data.rotated_y));
        end else begin
          want = expected_rotations.pop_front();
          if (rot_data.rotated_x !== want.rotated_x)
            report_mismatch($sformatf("result %0d rotated_x got %0d want %0d",
                                      result_count, rot_data.rotated_x, want.rotated_x));
          if (rot_data.rotated_y !== want.rotated_y)
            report_mismatch($sformatf("result %0d rotated_y got %0d want %0d",
                                      result_count, rot_data.rotated_y, want.rotated_y));
        end
        result_count++;
        // stall after a taken result for a random stretch
        stall_left = pick_gap(rot_calm);
      end
      if (stall_left > 0) begin
        stall_left--;
        rot_stall <= 1'b1;
      end else begin
        rot_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
